@@ src/esdm_pkg.sv @@
`default_nettype none

package esdm_pkg;

  // Field widths
  localparam int unsigned CprW    = 16;
  localparam int unsigned CircW   = 24;
  localparam int unsigned CountW  = 16;
  localparam int unsigned MsW     = 16;
  localparam int unsigned DeltaW  = 16;
  localparam int unsigned TotW    = 32;
  localparam int unsigned ResW    = 32;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 24;
  localparam logic [CfgIdxW-1:0] CfgCpr  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgCirc = 1'b1;

  localparam logic [CprW-1:0]  CprReset  = 16'd1320;
  localparam logic [CircW-1:0] CircReset = 24'd204204;

  // 60 s/min * 1000 ms/s * 1000 milli-rpm/rpm
  localparam int unsigned RpmScaleW = 26;
  localparam logic [RpmScaleW-1:0] RpmScale = 26'd60000000;
  // um per mm
  localparam int unsigned MmScaleW = 10;
  localparam logic [MmScaleW-1:0] MmScale = 10'd1000;

  // Quotient bits developed before saturation to 32-bit signed
  localparam int unsigned QuotW = 33;

  localparam int unsigned ChannelsDefault = 2;

  // Input action codes
  localparam logic ActSample = 1'b0;
  localparam logic ActClear  = 1'b1;

  typedef struct packed {
    logic              action;
    logic              channel;
    logic [CountW-1:0] counter_value;
    logic [MsW-1:0]    span_ms;
  } in_req_t;

  typedef struct packed {
    logic signed [DeltaW-1:0] delta_counts;
    logic signed [TotW-1:0]   total_counts;
    logic signed [ResW-1:0]   speed_milli_rpm;
    logic signed [ResW-1:0]   speed_mm_per_s;
    logic signed [ResW-1:0]   distance_mm;
  } out_rsp_t;

  // Divider control
  typedef struct packed {
    logic start;
    logic neg;   // result is negative
    logic zero;  // force result to zero
  } div_ctl_t;

endpackage

`default_nettype wire

@@ src/esdm_sermul.sv @@
`default_nettype none

// Shift-add multiplier, one multiplier bit per cycle.
module esdm_sermul #(
  parameter int unsigned AW = 16,
  parameter int unsigned BW = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [AW-1:0]   a_i,
  input  wire logic [BW-1:0]   b_i,
  output logic                 busy_o,
  output logic [AW+BW-1:0]     prod_o
);
  import esdm_pkg::*;

  localparam int unsigned PW   = AW + BW;
  localparam int unsigned CntW = $clog2(BW + 1);

  logic [PW-1:0]   m_q;
  logic [BW-1:0]   b_q;
  logic [PW-1:0]   p_q;
  logic [CntW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q   <= '0;
      b_q   <= '0;
      p_q   <= '0;
      cnt_q <= '0;
    end else if (start_i) begin
      m_q   <= PW'(a_i);
      b_q   <= b_i;
      p_q   <= '0;
      cnt_q <= CntW'(BW);
    end else if (cnt_q != '0) begin
      if (b_q[0]) begin
        p_q <= p_q + m_q;
      end
      m_q   <= m_q << 1;
      b_q   <= b_q >> 1;
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  assign busy_o = (cnt_q != '0);
  assign prod_o = p_q;

endmodule

`default_nettype wire

@@ src/esdm_serdiv.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// res = sign * round_half_away(mag / den), saturated to signed ResW.
module esdm_serdiv #(
  parameter int unsigned MagW = 56,
  parameter int unsigned DenW = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire esdm_pkg::div_ctl_t   ctl_i,
  input  wire logic [MagW-1:0]      mag_i,
  input  wire logic [DenW-1:0]      den_i,
  output logic                      busy_o,
  output logic signed [esdm_pkg::ResW-1:0] res_o
);
  import esdm_pkg::*;

  localparam int unsigned NW   = MagW + 2;
  localparam int unsigned HiW  = NW - QuotW;
  localparam int unsigned DW   = DenW + 1;
  localparam int unsigned CW   = (HiW > DW) ? HiW : DW;
  localparam int unsigned CntW = $clog2(QuotW + 1);

  typedef enum logic [1:0] {DvIdle, DvCheck, DvRun, DvSat} dv_state_e;

  dv_state_e         state_q;
  logic [NW-1:0]     n_q;
  logic [DW-1:0]     d_q;
  logic [DW-1:0]     rem_q;
  logic [QuotW-1:0]  q_q;
  logic [CntW-1:0]   cnt_q;
  logic              neg_q;
  logic              zero_q;
  logic              ovf_q;
  logic signed [ResW-1:0] res_q;

  logic [CW-1:0]     hi_ext;
  logic [CW-1:0]     d_ext;
  logic [DW:0]       shifted;
  logic [DW:0]       diff;
  logic              ge;
  logic [DW-1:0]     rem_d;
  logic              pos_big;
  logic              neg_big;
  logic [ResW-1:0]   q_lo;
  logic [ResW-1:0]   res_d;

  assign hi_ext  = CW'(n_q[NW-1:QuotW]);
  assign d_ext   = CW'(d_q);
  assign shifted = {rem_q, n_q[QuotW-1]};
  assign ge      = (shifted >= {1'b0, d_q});
  assign diff    = shifted - {1'b0, d_q};
  assign rem_d   = ge ? diff[DW-1:0] : shifted[DW-1:0];

  // Saturation bounds: +2^31-1 and -2^31
  assign q_lo    = q_q[ResW-1:0];
  assign pos_big = (q_q[QuotW-1:ResW-1] != '0);
  assign neg_big = (q_q[QuotW-1:ResW] != '0) || (q_q[ResW-1] && (q_q[ResW-2:0] != '0));

  always_comb begin
    if (zero_q) begin
      res_d = '0;
    end else if (neg_q) begin
      res_d = (ovf_q || neg_big) ? {1'b1, {(ResW-1){1'b0}}} : (~q_lo + ResW'(1));
    end else begin
      res_d = (ovf_q || pos_big) ? {1'b0, {(ResW-1){1'b1}}} : q_lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DvIdle;
      n_q     <= '0;
      d_q     <= '0;
      rem_q   <= '0;
      q_q     <= '0;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      zero_q  <= 1'b0;
      ovf_q   <= 1'b0;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        DvIdle: begin
          if (ctl_i.start) begin
            // round half away: (2*mag + den) / (2*den)
            n_q     <= NW'({mag_i, 1'b0}) + NW'(den_i);
            d_q     <= {den_i, 1'b0};
            neg_q   <= ctl_i.neg;
            zero_q  <= ctl_i.zero;
            state_q <= DvCheck;
          end
        end
        DvCheck: begin
          q_q <= '0;
          if (hi_ext >= d_ext) begin
            ovf_q   <= 1'b1;
            state_q <= DvSat;
          end else begin
            ovf_q   <= 1'b0;
            rem_q   <= hi_ext[DW-1:0];
            cnt_q   <= CntW'(QuotW);
            state_q <= DvRun;
          end
        end
        DvRun: begin
          rem_q <= rem_d;
          q_q   <= {q_q[QuotW-2:0], ge};
          n_q   <= n_q << 1;
          cnt_q <= cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            state_q <= DvSat;
          end
        end
        DvSat: begin
          res_q   <= res_d;
          state_q <= DvIdle;
        end
        default: state_q <= DvIdle;
      endcase
    end
  end

  assign busy_o = (state_q != DvIdle);
  assign res_o  = res_q;

endmodule

`default_nettype wire

@@ src/encoder_speed_distance_meter.sv @@
// Encoder speed and distance meter.
// Input channel (in_valid_i / in_ready_o / in_req_i): one request per encoder
// sample or per clear. A sample gives the channel's 16-bit counter snapshot and
// the milliseconds since the last sample; a clear zeroes that channel.
// Output channel (out_valid_o / out_ready_i / out_rsp_o): exactly one result
// per request: count delta, wrapping running total, speed in milli-rpm and
// mm/s, and distance in mm, each rounded half away from zero and saturated.
// Config port (cfg_we_i / cfg_idx_i / cfg_wdata_i): counts per revolution and
// wheel circumference in um; write only while no request is in flight.
// A request passes setup, the serial multiplies (their length set by the
// 24-bit circumference), the divider launch, the divider (range check, 33
// quotient bits, saturation) and the output register. One request is worked
// at a time; the next is taken the cycle after the result enters the output
// register. A stalled receiver holds the result in the output register; one
// more request can be worked meanwhile, then input stalls too.
// Reset: channel counters and totals cleared, registers to their defaults.
`default_nettype none

module encoder_speed_distance_meter #(
  parameter int unsigned Channels = esdm_pkg::ChannelsDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire esdm_pkg::in_req_t               in_req_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output esdm_pkg::out_rsp_t                   out_rsp_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [esdm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [esdm_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import esdm_pkg::*;

  typedef enum logic [2:0] {StIdle, StLoad, StMul, StDivGo, StDiv, StDone} st_e;

  // Config registers
  logic [CprW-1:0]  cpr_q;
  logic [CircW-1:0] circ_q;

  // Per-channel state
  logic [CountW-1:0] prev_q [Channels];
  logic [TotW-1:0]   tot_q  [Channels];

  st_e               state_q;
  logic [DeltaW-1:0] delta_q;     // delta of this request (0 when not updated)
  logic [TotW-1:0]   total_q;     // total reported for this request
  logic [MsW-1:0]    ms_q;
  logic              zero_spd_q;
  logic              zero_dist_q;
  logic              out_valid_q;
  out_rsp_t          out_rsp_q;

  logic              accept;
  logic              ch_ok;
  logic              req_ok;
  logic              upd;
  logic [CountW-1:0] sel_prev;
  logic [TotW-1:0]   sel_tot;
  logic [DeltaW-1:0] d_raw;
  logic [TotW-1:0]   new_tot;

  logic [DeltaW-1:0] mag_d;
  logic [TotW-1:0]   mag_t;
  logic              mul_start;
  logic              mul_busy;
  logic              div_busy;

  logic [RpmScaleW+DeltaW-1:0] prod_rpm;
  logic [CircW+DeltaW-1:0]     prod_mms;
  logic [TotW+CircW-1:0]       prod_dist;
  logic [CprW+MsW-1:0]         den_spd;
  logic [CprW+MmScaleW-1:0]    den_dist;
  logic                        busy_rpm, busy_mms, busy_dist, busy_den, busy_dden;

  div_ctl_t               ctl_spd_rpm, ctl_spd_mms, ctl_dist;
  logic signed [ResW-1:0] res_rpm, res_mms, res_dist;
  logic                   dbusy_rpm, dbusy_mms, dbusy_dist;

  // ---------------------------------------------------------------
  // Request decode and channel lookup
  // ---------------------------------------------------------------
  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign ch_ok      = (32'(in_req_i.channel) < Channels);
  assign req_ok     = ch_ok && (in_req_i.action == ActSample);
  // An update needs nonzero time and a nonzero counts-per-rev
  assign upd        = req_ok && (in_req_i.span_ms != '0) && (cpr_q != '0);

  always_comb begin
    sel_prev = '0;
    sel_tot  = '0;
    for (int i = 0; i < Channels; i++) begin
      if (32'(in_req_i.channel) == 32'(i)) begin
        sel_prev = prev_q[i];
        sel_tot  = tot_q[i];
      end
    end
  end

  // Wrap-around delta of the 16-bit counter, sign-extended into the total
  assign d_raw   = in_req_i.counter_value - sel_prev;
  assign new_tot = sel_tot + {{(TotW-DeltaW){d_raw[DeltaW-1]}}, d_raw};

  // ---------------------------------------------------------------
  // Sequencer, channel state, output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cpr_q       <= CprReset;
      circ_q      <= CircReset;
      delta_q     <= '0;
      total_q     <= '0;
      ms_q        <= '0;
      zero_spd_q  <= 1'b1;
      zero_dist_q <= 1'b1;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
      for (int i = 0; i < Channels; i++) begin
        prev_q[i] <= '0;
        tot_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgCpr:  cpr_q  <= cfg_wdata_i[CprW-1:0];
          CfgCirc: circ_q <= cfg_wdata_i[CircW-1:0];
          default: ;
        endcase
      end

      // StDone reloads the register itself when it is emptied there
      if (out_valid_q && out_ready_i && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (accept) begin
            delta_q     <= upd ? d_raw : '0;
            total_q     <= req_ok ? (upd ? new_tot : sel_tot) : '0;
            ms_q        <= in_req_i.span_ms;
            zero_spd_q  <= !upd;
            zero_dist_q <= !(req_ok && (cpr_q != '0));
            for (int i = 0; i < Channels; i++) begin
              if (32'(in_req_i.channel) == 32'(i)) begin
                if (ch_ok && (in_req_i.action == ActClear)) begin
                  prev_q[i] <= '0;
                  tot_q[i]  <= '0;
                end else if (upd) begin
                  prev_q[i] <= in_req_i.counter_value;
                  tot_q[i]  <= new_tot;
                end
              end
            end
            state_q <= StLoad;
          end
        end
        StLoad:  state_q <= StMul;
        StMul: begin
          if (!mul_busy) begin
            state_q <= StDivGo;
          end
        end
        StDivGo: state_q <= StDiv;
        StDiv: begin
          if (!div_busy) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          // output register free, or emptied this cycle
          if (!out_valid_q || out_ready_i) begin
            out_valid_q               <= 1'b1;
            out_rsp_q.delta_counts    <= delta_q;
            out_rsp_q.total_counts    <= total_q;
            out_rsp_q.speed_milli_rpm <= res_rpm;
            out_rsp_q.speed_mm_per_s  <= res_mms;
            out_rsp_q.distance_mm     <= res_dist;
            state_q                   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // ---------------------------------------------------------------
  // Serial multipliers: numerators and denominators in parallel
  // ---------------------------------------------------------------
  assign mag_d     = delta_q[DeltaW-1] ? (~delta_q + DeltaW'(1)) : delta_q;
  assign mag_t     = total_q[TotW-1] ? (~total_q + TotW'(1)) : total_q;
  assign mul_start = (state_q == StLoad);
  assign mul_busy  = busy_rpm | busy_mms | busy_dist | busy_den | busy_dden;

  // |delta| * 60e6
  esdm_sermul #(.AW(RpmScaleW), .BW(DeltaW)) u_mul_rpm (
    .clk_i, .rst_ni, .start_i(mul_start),
    .a_i(RpmScale), .b_i(mag_d), .busy_o(busy_rpm), .prod_o(prod_rpm)
  );

  // |delta| * circumference
  esdm_sermul #(.AW(CircW), .BW(DeltaW)) u_mul_mms (
    .clk_i, .rst_ni, .start_i(mul_start),
    .a_i(circ_q), .b_i(mag_d), .busy_o(busy_mms), .prod_o(prod_mms)
  );

  // |total| * circumference; the 24-bit circumference operand sets the multiply phase length
  esdm_sermul #(.AW(TotW), .BW(CircW)) u_mul_dist (
    .clk_i, .rst_ni, .start_i(mul_start),
    .a_i(mag_t), .b_i(circ_q), .busy_o(busy_dist), .prod_o(prod_dist)
  );

  // cpr * ms
  esdm_sermul #(.AW(CprW), .BW(MsW)) u_mul_den (
    .clk_i, .rst_ni, .start_i(mul_start),
    .a_i(cpr_q), .b_i(ms_q), .busy_o(busy_den), .prod_o(den_spd)
  );

  // cpr * 1000
  esdm_sermul #(.AW(CprW), .BW(MmScaleW)) u_mul_dden (
    .clk_i, .rst_ni, .start_i(mul_start),
    .a_i(cpr_q), .b_i(MmScale), .busy_o(busy_dden), .prod_o(den_dist)
  );

  // ---------------------------------------------------------------
  // Serial dividers with rounding and saturation
  // ---------------------------------------------------------------
  assign ctl_spd_rpm = '{start: (state_q == StDivGo), neg: delta_q[DeltaW-1],
                         zero: zero_spd_q};
  assign ctl_spd_mms = ctl_spd_rpm;
  assign ctl_dist    = '{start: (state_q == StDivGo), neg: total_q[TotW-1],
                         zero: zero_dist_q};
  assign div_busy    = dbusy_rpm | dbusy_mms | dbusy_dist;

  esdm_serdiv #(.MagW(RpmScaleW+DeltaW), .DenW(CprW+MsW)) u_div_rpm (
    .clk_i, .rst_ni, .ctl_i(ctl_spd_rpm), .mag_i(prod_rpm), .den_i(den_spd),
    .busy_o(dbusy_rpm), .res_o(res_rpm)
  );

  esdm_serdiv #(.MagW(CircW+DeltaW), .DenW(CprW+MsW)) u_div_mms (
    .clk_i, .rst_ni, .ctl_i(ctl_spd_mms), .mag_i(prod_mms), .den_i(den_spd),
    .busy_o(dbusy_mms), .res_o(res_mms)
  );

  esdm_serdiv #(.MagW(TotW+CircW), .DenW(CprW+MmScaleW)) u_div_dist (
    .clk_i, .rst_ni, .ctl_i(ctl_dist), .mag_i(prod_dist), .den_i(den_dist),
    .busy_o(dbusy_dist), .res_o(res_dist)
  );

endmodule

`default_nettype wire

@@ sim/esdm_checker.sv @@
`timescale 1ns / 100ps

module esdm_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  esdm_pkg::in_req_t               in_req_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  esdm_pkg::out_rsp_t              out_rsp_i,
  input  logic                            cfg_we_i,
  input  logic [esdm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [esdm_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output int unsigned                     outstanding_o,
  output int unsigned                     fail_count_o
);
  import esdm_pkg::*;

  typedef longint unsigned u64_t;

  logic [CprW-1:0]   cpr;
  logic [CircW-1:0]  circ;
  logic [CountW-1:0] prev_cnt [ChannelsDefault];
  logic [TotW-1:0]   run_tot  [ChannelsDefault];
  out_rsp_t          meas_q   [$];
  int unsigned       n_fail = 0;

  // num / den, half away from zero, clamped to 32-bit signed
  function automatic logic signed [ResW-1:0] div_round_sat(input longint num, input u64_t den);
    logic neg;
    u64_t mag;
    u64_t q;
    neg = (num < 0);
    mag = neg ? u64_t'(-num) : u64_t'(num);
    q   = (2 * mag + den) / (2 * den);
    if (neg) begin
      if (q > 64'd2147483648) q = 64'd2147483648;
      q = -q;
    end else if (q > 64'd2147483647) begin
      q = 64'd2147483647;
    end
    return q[ResW-1:0];
  endfunction

  // Updates the channel state and returns the measurement for one request
  function automatic out_rsp_t compute_meas(input in_req_t r);
    out_rsp_t m;
    logic [CountW-1:0] step;
    u64_t den;
    m = '0;
    if (r.action == ActClear) begin
      prev_cnt[r.channel] = '0;
      run_tot[r.channel]  = '0;
      return m;
    end
    if (r.span_ms != '0 && cpr != '0) begin
      step = r.counter_value - prev_cnt[r.channel];
      prev_cnt[r.channel] = r.counter_value;
      run_tot[r.channel]  = run_tot[r.channel] + {{(TotW-CountW){step[CountW-1]}}, step};
      den = u64_t'(cpr) * u64_t'(r.span_ms);
      m.delta_counts    = step;
      m.speed_milli_rpm = div_round_sat(longint'($signed(step)) * longint'(RpmScale), den);
      m.speed_mm_per_s  = div_round_sat(longint'($signed(step)) * longint'(circ), den);
    end
    m.total_counts = run_tot[r.channel];
    if (cpr != '0) begin
      m.distance_mm = div_round_sat(longint'($signed(run_tot[r.channel])) * longint'(circ),
                                    u64_t'(cpr) * u64_t'(MmScale));
    end
    return m;
  endfunction

  task automatic cmp_field(input string name, input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
      n_fail++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_rsp_t want;
    if (!rst_ni) begin
      cpr  = CprReset;
      circ = CircReset;
      for (int i = 0; i < ChannelsDefault; i++) begin
        prev_cnt[i] = '0;
        run_tot[i]  = '0;
      end
      meas_q.delete();
      outstanding_o <= 0;
      fail_count_o  <= 0;
    end else begin
      // result first: it always belongs to an older request
      if (out_valid_i && out_ready_i) begin
        if (meas_q.size() == 0) begin
          $display("%0t: unexpected result, expected none got total %0d", $time,
                   $signed(out_rsp_i.total_counts));
          n_fail++;
        end else begin
          want = meas_q.pop_front();
          cmp_field("delta_counts", $signed(want.delta_counts),
                    $signed(out_rsp_i.delta_counts));
          cmp_field("total_counts", $signed(want.total_counts),
                    $signed(out_rsp_i.total_counts));
          cmp_field("speed_milli_rpm", $signed(want.speed_milli_rpm),
                    $signed(out_rsp_i.speed_milli_rpm));
          cmp_field("speed_mm_per_s", $signed(want.speed_mm_per_s),
                    $signed(out_rsp_i.speed_mm_per_s));
          cmp_field("distance_mm", $signed(want.distance_mm),
                    $signed(out_rsp_i.distance_mm));
        end
      end
      if (in_valid_i && in_ready_i) meas_q.push_back(compute_meas(in_req_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgCpr:  cpr  = cfg_wdata_i[CprW-1:0];
          CfgCirc: circ = cfg_wdata_i[CircW-1:0];
          default: ;
        endcase
      end
      outstanding_o <= meas_q.size();
      fail_count_o  <= n_fail;
    end
  end

endmodule

@@ sim/tb_encoder_speed_distance_meter.sv @@
`timescale 1ns / 100ps

module tb_encoder_speed_distance_meter;
  import esdm_pkg::*;

  // Quiet cycles (nothing accepted on either channel) before the run is
  // declared hung. Worst legit quiet stretch is the receiver hold below plus
  // a request latency and a config pause, so this is several times over.
  localparam int unsigned StallLimit  = 4000;
  // Receiver hold-off used to back the block up until it drops in_ready
  localparam int unsigned HoldCycles  = 400;
  // Extra cycles after the last result to catch stray output
  localparam int unsigned DrainCycles = 80;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_req_t              in_req    = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_rsp_t             out_rsp;
  logic                 cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx   = CfgCpr;
  logic [CfgDataW-1:0]  cfg_wdata = '0;

  int unsigned          outstanding;
  int unsigned          fail_count;

  // Stimulus-side knobs, written with NBAs by the stimulus process only
  logic                 no_idle   = 1'b0;
  int unsigned          hold_reqs = 0;
  // Last counter value per channel, only used to shape realistic deltas
  logic [CountW-1:0]    last_cnt [ChannelsDefault];

  initial begin
    forever #1 clk = ~clk;
  end

  encoder_speed_distance_meter DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  esdm_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_req_i      (in_req),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_rsp_i     (out_rsp),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  function automatic in_req_t mk(input logic act, input logic ch,
                                 input logic [CountW-1:0] cnt, input logic [MsW-1:0] ms);
    in_req_t r;
    r.action        = act;
    r.channel       = ch;
    r.counter_value = cnt;
    r.span_ms       = ms;
    return r;
  endfunction

  // Mostly plausible encoder motion, with clears, zero-time samples,
  // fully random snapshots and half-range jumps mixed in.
  function automatic in_req_t rand_req();
    logic ch;
    int unsigned pick;
    logic [CountW-1:0] cnt;
    ch   = 1'($urandom);
    pick = $urandom_range(99);
    cnt  = last_cnt[ch];
    if (pick < 5) return mk(ActClear, ch, 16'($urandom), 16'($urandom));
    if (pick < 10) return mk(ActSample, ch, 16'($urandom), '0);
    if (pick < 20) return mk(ActSample, ch, 16'($urandom), 16'($urandom));
    if (pick < 25) begin
      return mk(ActSample, ch, cnt + ((pick < 23) ? 16'h7FFF : 16'h8000),
                16'($urandom_range(3, 1)));
    end
    return mk(ActSample, ch, cnt + 16'($urandom_range(6000)) - 16'd3000,
              16'($urandom_range(200, 1)));
  endfunction

  // Present one request and hold it until accepted. Valid is only dropped
  // when an idle gap is taken, so back-to-back requests keep it high.
  task automatic offer(input in_req_t r);
    while (!no_idle && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    if (r.action == ActClear) last_cnt[r.channel] = '0;
    else if (r.span_ms != '0) last_cnt[r.channel] = r.counter_value;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every result has come back.
  // Each request yields exactly one result, so the block is idle then.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Both registers written back to back, only while idle
  task automatic set_config(input logic [CfgDataW-1:0] cpr_word,
                            input logic [CfgDataW-1:0] circ_word);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgCpr;
    cfg_wdata <= cpr_word;
    @(posedge clk);
    cfg_idx   <= CfgCirc;
    cfg_wdata <= circ_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(input int unsigned n, input logic with_hold);
    for (int unsigned k = 0; k < n; k++) begin
      // kick off the long receiver hold a third of the way in
      if (with_hold && k == n / 3) hold_reqs <= hold_reqs + 1;
      offer(rand_req());
    end
  endtask

  // Receiver side: random back-pressure, none while no_idle is set, and a
  // long hold each time the stimulus asks for one.
  initial begin : rsp_side
    int unsigned hold_left;
    int unsigned holds_done;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done != hold_reqs) begin
        holds_done++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 37);
      end
    end
  end

  // Hang detector: counts cycles with no handshake on either side
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    last_cnt[0] = '0;
    last_cnt[1] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // --- default registers: basic motion, wrap-around, zero time, clear ---
    offer(mk(ActSample, 1'b0, 16'd100, 16'd10));
    offer(mk(ActSample, 1'b0, 16'd50, 16'd7));          // reverse motion
    offer(mk(ActSample, 1'b0, 16'hFFFF, 16'd0));        // zero time: no update
    offer(mk(ActSample, 1'b0, 16'hFFFF, 16'hFFFF));     // longest interval
    offer(mk(ActSample, 1'b1, 16'hFFFF, 16'd1));        // wraps to -1
    offer(mk(ActSample, 1'b1, 16'h0001, 16'd1));        // wraps forward +2
    offer(mk(ActSample, 1'b1, 16'h8000, 16'd1));        // largest positive step
    offer(mk(ActSample, 1'b1, 16'h0000, 16'd1));        // largest negative step
    offer(mk(ActClear,  1'b1, 16'hFFFF, 16'hFFFF));     // clear ignores payload
    offer(mk(ActSample, 1'b1, 16'h1234, 16'd3));
    // 11 counts over 64 ms gives exactly 7812.5 milli-rpm: ties round away
    offer(mk(ActSample, 1'b1, 16'h123F, 16'd64));
    offer(mk(ActSample, 1'b1, 16'h1234, 16'd64));
    run_random(250, 1'b0);

    // --- one count per rev, widest wheel: the directed samples saturate the speeds ---
    // upper data bits on the 16-bit register must be dropped
    set_config({8'($urandom), 16'd1}, 24'hFFFFFF);
    offer(mk(ActClear, 1'b0, 16'h0, 16'h0));
    for (int i = 1; i <= 4; i++) offer(mk(ActSample, 1'b0, 16'(i * 32767), 16'd1));
    for (int i = 1; i <= 9; i++) begin
      offer(mk(ActSample, 1'b0, 16'(4 * 32767 + i * 32768), 16'd1));
    end
    run_random(200, 1'b0);

    // --- counts per rev written as zero: nothing moves, distance reads zero ---
    set_config(24'hC30000, 24'($urandom));
    offer(mk(ActSample, 1'b1, 16'h4321, 16'd5));
    offer(mk(ActSample, 1'b0, 16'h0000, 16'd0));
    run_random(40, 1'b0);

    // --- finest encoder, narrowest wheel, full throughput on both sides ---
    set_config(24'hFFFFFF, 24'd1);
    no_idle <= 1'b1;
    run_random(250, 1'b0);
    no_idle <= 1'b0;

    // --- random registers, with the receiver backing up the block ---
    set_config(24'($urandom), 24'($urandom));
    run_random(300, 1'b1);

    // --- coarse encoder on the default wheel ---
    set_config({8'h00, 16'd4}, 24'(CircReset));
    run_random(330, 1'b0);

    settle();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
